### hw/rtl/sotr_pkg.sv
`default_nettype none

package sotr_pkg;

   // Default ring capacity
   localparam int DEPTH_DEF = 16;

   // Field widths
   localparam int TYPE_W   = 3;
   localparam int ID_W     = 8;
   localparam int SPD_W    = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int ENTRY_W  = ID_W + SPD_W;

   // Stream payload widths (byte aligned)
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_SPEED   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_FRONT   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_END     = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REMOVE  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_ADVANCE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_QUERY   = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic decide;
      logic walk;
      logic tail;
      logic fetch;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_insert;
      logic is_end;
      logic is_query;
      logic empty;
      logic full;
      logic walk_done;
   } stat_type;

endpackage

`default_nettype wire

### hw/rtl/sotr_ram.sv
`default_nettype none

module sotr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/sotr_ctrl.sv
`default_nettype none

module sotr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output sotr_pkg::cmd_type        cmd,
   input  wire sotr_pkg::stat_type  stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_TAIL   = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       skip;

   // Refused requests and queries go straight to the final read
   assign skip = (stat.is_insert && stat.full) || (!stat.is_insert && stat.empty) ||
                 stat.is_query;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (skip)             state_in = S_FETCH;
            else if (stat.is_end) state_in = S_TAIL;
            else                  state_in = S_WALK;
         end
         S_WALK: begin
            if (stat.walk_done) state_in = S_TAIL;
         end
         S_TAIL:  state_in = S_FETCH;
         S_FETCH: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshakes and commands; both channels are quiet during reset
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = (state_ff == S_RESP) && !reset;

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.decide = (state_ff == S_DECIDE);
   assign cmd.walk   = (state_ff == S_WALK);
   assign cmd.tail   = (state_ff == S_TAIL);
   assign cmd.fetch  = (state_ff == S_FETCH);

endmodule

`default_nettype wire

### hw/rtl/sotr_dpath.sv
`default_nettype none

module sotr_dpath #(
   parameter int DEPTH = sotr_pkg::DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sotr_pkg::cmd_type               cmd,
   output sotr_pkg::stat_type                   stat,
   input  wire logic [sotr_pkg::TYPE_W-1:0]     req_type,
   input  wire logic [sotr_pkg::ID_W-1:0]       entry_id,
   input  wire logic [sotr_pkg::SPD_W-1:0]      entry_speed,
   output logic      [sotr_pkg::STATUS_W-1:0]   status,
   output logic                                 active_valid,
   output logic      [sotr_pkg::ID_W-1:0]       active_id,
   output logic      [sotr_pkg::COUNT_W-1:0]    entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int EW    = sotr_pkg::ENTRY_W;

   logic [sotr_pkg::TYPE_W-1:0]   op_ff;
   logic [sotr_pkg::ID_W-1:0]     id_ff;
   logic [sotr_pkg::SPD_W-1:0]    spd_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              idx_ff;
   logic                          placed_ff;
   logic [EW-1:0]                 carry_ff;
   logic [sotr_pkg::STATUS_W-1:0] status_ff;

   logic                          is_insert;
   logic                          is_front;
   logic                          is_remove;
   logic                          is_adv;
   logic [CNT_W-1:0]              pos;
   logic [EW-1:0]                 new_entry;
   logic [EW-1:0]                 rd_data;
   logic [sotr_pkg::ID_W-1:0]     rd_id;
   logic [sotr_pkg::SPD_W-1:0]    rd_spd;
   logic                          proc;
   logic                          ins_hit;
   logic                          drop_hit;
   logic                          wr_en;
   logic [CNT_W-1:0]              wr_pos;
   logic [EW-1:0]                 wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;

   // Request decode
   assign is_insert = (op_ff == sotr_pkg::REQ_SPEED) || (op_ff == sotr_pkg::REQ_FRONT) ||
                      (op_ff == sotr_pkg::REQ_END);
   assign is_front  = (op_ff == sotr_pkg::REQ_FRONT);
   assign is_remove = (op_ff == sotr_pkg::REQ_REMOVE);
   assign is_adv    = (op_ff == sotr_pkg::REQ_ADVANCE);

   assign stat.is_insert = is_insert;
   assign stat.is_end    = (op_ff == sotr_pkg::REQ_END);
   assign stat.is_query  = !is_insert && !is_remove && !is_adv;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.walk_done = (idx_ff == count_ff);

   // Entry at position pos arrives from the RAM while idx_ff points one ahead
   assign pos       = idx_ff - CNT_W'(1);
   assign new_entry = {spd_ff, id_ff};
   assign rd_id     = rd_data[sotr_pkg::ID_W-1:0];
   assign rd_spd    = rd_data[EW-1:sotr_pkg::ID_W];
   assign proc      = cmd.walk && (idx_ff != '0);
   assign ins_hit   = is_front ? (pos == '0) : (rd_spd <= spd_ff);
   assign drop_hit  = (is_remove && (rd_id == id_ff)) || (is_adv && (pos == '0));

   // Write port: ripple a carried entry forward on insert, pull entries back on drop
   always_comb begin
      wr_en   = 1'b0;
      wr_pos  = pos;
      wr_data = carry_ff;
      if (proc) begin
         if (is_insert) begin
            wr_en   = placed_ff || ins_hit;
            wr_data = placed_ff ? carry_ff : new_entry;
         end else begin
            wr_en   = placed_ff;
            wr_pos  = pos - CNT_W'(1);
            wr_data = rd_data;
         end
      end else if (cmd.tail) begin
         if (is_insert) begin
            wr_en   = 1'b1;
            wr_pos  = count_ff;
            wr_data = placed_ff ? carry_ff : new_entry;
         end else if (is_adv) begin
            wr_en   = 1'b1;
            wr_pos  = count_ff - CNT_W'(1);
         end
      end
   end

   // Read port: walk sequentially, or fetch the active entry
   assign rd_en   = (cmd.walk && (idx_ff < count_ff)) || cmd.fetch;
   assign rd_addr = cmd.fetch ? '0 : idx_ff[IDX_W-1:0];

   sotr_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_pos[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.tail) begin
         if (is_insert) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (is_remove && placed_ff) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Request latch, walk index, carry and status
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_type;
         id_ff     <= entry_id;
         spd_ff    <= entry_speed;
         idx_ff    <= '0;
         placed_ff <= 1'b0;
      end
      if (cmd.decide) begin
         if (is_insert && stat.full) begin
            status_ff <= sotr_pkg::ST_FULL;
         end else if (!is_insert && stat.empty) begin
            status_ff <= sotr_pkg::ST_EMPTY;
         end else begin
            status_ff <= sotr_pkg::ST_OK;
         end
      end
      if (cmd.walk) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (proc) begin
         if (is_insert) begin
            if (placed_ff || ins_hit) begin
               carry_ff  <= rd_data;
               placed_ff <= 1'b1;
            end
         end else if (!placed_ff && drop_hit) begin
            carry_ff  <= rd_data;
            placed_ff <= 1'b1;
         end
      end
      if (cmd.tail && is_remove && !placed_ff) begin
         status_ff <= sotr_pkg::ST_NOT_FOUND;
      end
   end

   // Result fields, stable while the response waits
   assign status       = status_ff;
   assign active_valid = (count_ff != '0);
   assign active_id    = active_valid ? rd_id : '0;
   assign entry_count  = sotr_pkg::COUNT_W'(count_ff);

endmodule

`default_nettype wire

### hw/rtl/speed_ordered_turn_ring.sv
// Speed ordered turn ring.
// Holds up to DEPTH entries (id, speed) in turn order from the active entry.
// req channel: one transaction per request: insert by speed, insert at
// front, insert at end, remove by id, advance the turn, or query.
// rsp channel: exactly one transaction per request with status, whether an
// active entry exists, the active id and the entry count afterwards.
// One request is handled at a time. A request that walks the ring passes
// through the decide, walk, tail, fetch and response states after it is
// accepted; insert at end skips the walk, and refused inserts, queries and
// remove or advance on an empty ring go from decide straight to fetch. Once
// the response is taken, the controller returns to idle and accepts the next
// request there. The walk reads and rewrites one entry per cycle through
// the single read and write port of the entry RAM.
// req_tready is high only while no request is in progress, so a stalled
// rsp channel holds the response steady and blocks the next request.
// Reset empties the ring at once; entry storage is not cleared.
`default_nettype none

module speed_ordered_turn_ring #(
   parameter int DEPTH = sotr_pkg::DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [2:0] req_type, [10:3] entry_id, [18:11] entry_speed, [23:19] zero
   input  wire logic [sotr_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [1:0] status, [2] active_valid, [10:3] active_id, [15:11] entry_count
   output logic      [sotr_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   sotr_pkg::cmd_type                cmd;
   sotr_pkg::stat_type               stat;
   logic [sotr_pkg::STATUS_W-1:0]    status;
   logic                             active_valid;
   logic [sotr_pkg::ID_W-1:0]        active_id;
   logic [sotr_pkg::COUNT_W-1:0]     entry_count;

   sotr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sotr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_tdata[2:0]),
      .entry_id     (req_tdata[10:3]),
      .entry_speed  (req_tdata[18:11]),
      .status       (status),
      .active_valid (active_valid),
      .active_id    (active_id),
      .entry_count  (entry_count)
   );

   // Response packing
   assign rsp_tdata = {entry_count, active_id, active_valid, status};

endmodule

`default_nettype wire
